>>> rtl/assert_macros.svh
// Assertion helpers for the fuzzy gain-scheduled PID block.
// Each macro expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fgpid: assertion failed");

// Next-cycle implication, checked out of reset
`define FG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fgpid: assertion failed");

`endif

>>> rtl/fgpid_pkg.sv
// ----------------------------------------------------------------------------
// fgpid_pkg
// Shared constants, rule tables, types and helper functions of the fuzzy
// gain-scheduled PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fgpid_pkg;

    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int INTEG_W     = 48;
    localparam int PERIOD_FRAC = 24;
    localparam int CFG_IDX_W   = 3;

    // Serial multiplier geometry: 63-bit magnitude times 33-bit magnitude
    localparam int MUL_A_W   = 63;
    localparam int MUL_B_W   = 33;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;
    localparam int MUL_CNT_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PER    = 3'd4;

    // Operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Level bounds: 0.1 (rounded), 0.5 and 1.5
    localparam logic signed [63:0] T01 = 64'sd6554;
    localparam logic signed [63:0] T05 = 64'sd32768;
    localparam logic signed [63:0] T15 = 64'sd98304;

    // Gain offsets for rule magnitudes 1..3, rounded half away from zero
    localparam logic signed [32:0] KP_OFS1 = 33'(((1 << (FRAC_W + 1)) / 6 + 1) >> 1);
    localparam logic signed [32:0] KP_OFS2 = 33'(((2 << (FRAC_W + 1)) / 6 + 1) >> 1);
    localparam logic signed [32:0] KP_OFS3 = 33'(((3 << (FRAC_W + 1)) / 6 + 1) >> 1);
    localparam logic signed [32:0] KI_OFS1 = 33'(((1 << (FRAC_W + 1)) / 30 + 1) >> 1);
    localparam logic signed [32:0] KI_OFS2 = 33'(((2 << (FRAC_W + 1)) / 30 + 1) >> 1);
    localparam logic signed [32:0] KI_OFS3 = 33'(((3 << (FRAC_W + 1)) / 30 + 1) >> 1);
    localparam logic signed [32:0] KD_OFS1 = 33'(((1 << (FRAC_W + 1)) / 15 + 1) >> 1);
    localparam logic signed [32:0] KD_OFS2 = 33'(((2 << (FRAC_W + 1)) / 15 + 1) >> 1);
    localparam logic signed [32:0] KD_OFS3 = 33'(((3 << (FRAC_W + 1)) / 15 + 1) >> 1);

    typedef logic signed [2:0] rule_t;

    localparam rule_t PROP_TBL [7][7] = '{
        '{3'sd3, 3'sd3, 3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd0},
        '{3'sd3, 3'sd3, 3'sd2, 3'sd2, 3'sd1, 3'sd1, -3'sd1},
        '{3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd0, -3'sd1, -3'sd2},
        '{3'sd2, 3'sd1, 3'sd0, -3'sd1, -3'sd1, -3'sd2, -3'sd2},
        '{3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd2, -3'sd2, -3'sd2},
        '{3'sd1, 3'sd0, -3'sd1, -3'sd2, -3'sd2, -3'sd3, -3'sd3},
        '{3'sd0, 3'sd0, -3'sd1, -3'sd2, -3'sd3, -3'sd3, -3'sd3}};

    localparam rule_t INTEG_TBL [7][7] = '{
        '{-3'sd3, -3'sd3, -3'sd3, -3'sd2, -3'sd2, -3'sd1, 3'sd0},
        '{-3'sd3, -3'sd3, -3'sd2, -3'sd2, -3'sd1, 3'sd0, 3'sd0},
        '{-3'sd2, -3'sd2, -3'sd1, -3'sd1, 3'sd0, 3'sd1, 3'sd1},
        '{-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd1, 3'sd2, 3'sd2},
        '{-3'sd1, 3'sd0, 3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd3},
        '{3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3, 3'sd3},
        '{3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3, 3'sd3, 3'sd3}};

    localparam rule_t DERIV_TBL [7][7] = '{
        '{3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd2, 3'sd0},
        '{3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1, 3'sd0},
        '{3'sd1, 3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd1, 3'sd0},
        '{3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd2},
        '{3'sd0, 3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd1, 3'sd2}};

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_RATE, ST_LEVEL, ST_GAIN, ST_PROP, ST_ITERM, ST_INC,
        ST_INTEG, ST_DTERM, ST_DRATE, ST_SUM, ST_OUT
    } fgpid_state_t;

    // Multiplier request and status
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a_mag;
        logic [MUL_B_W-1:0] b_mag;
        logic               shift24;
        logic               negate;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Classify a value into one of seven levels; a bound belongs to the lower level
    function automatic logic [2:0] level_of(input logic signed [63:0] x);
        logic [2:0] lv;
        priority if (x <= -T15) lv = 3'd0;
        else if (x <= -T05)     lv = 3'd1;
        else if (x <= -T01)     lv = 3'd2;
        else if (x <= T01)      lv = 3'd3;
        else if (x <= T05)      lv = 3'd4;
        else if (x <= T15)      lv = 3'd5;
        else                    lv = 3'd6;
        return lv;
    endfunction

    // Map a rule entry to its signed gain offset from three magnitudes
    function automatic logic signed [32:0] rule_offset(input rule_t v,
                                                       input logic signed [32:0] o1,
                                                       input logic signed [32:0] o2,
                                                       input logic signed [32:0] o3);
        logic signed [32:0] r;
        unique case (v)
            3'sd1:   r = o1;
            3'sd2:   r = o2;
            3'sd3:   r = o3;
            -3'sd1:  r = -o1;
            -3'sd2:  r = -o2;
            -3'sd3:  r = -o3;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fgpid_serial_mult.sv
// ----------------------------------------------------------------------------
// fgpid_serial_mult
// Bit-serial shift-add multiplier of two magnitudes. One multiplier bit is
// consumed per cycle while busy; a final step shifts, saturates to 2^62 and signs.
// ----------------------------------------------------------------------------
`default_nettype none

module fgpid_serial_mult import fgpid_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mul_req_t           req,
    output      mul_stat_t          stat,
    output      logic signed [63:0] result
);

    logic                 busy_reg, fin_reg, done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_P_W-1:0]   acc_reg;
    logic                 sh24_reg, neg_reg;
    logic signed [63:0]   res_reg;

    logic [MUL_A_W+1:0]   part_sum;
    logic [MUL_P_W-1:0]   acc_next;
    logic [MUL_P_W-1:0]   shifted;
    logic                 over;
    logic [62:0]          mag;
    logic signed [63:0]   res_next;

    // Add the multiplicand when the current multiplier bit is set, then shift right
    always_comb begin
        part_sum = {1'b0, acc_reg[MUL_P_W-1:MUL_B_W]}
                 + (b_reg[0] ? {2'b00, a_reg} : '0);
        acc_next = {part_sum, acc_reg[MUL_B_W-1:1]};
    end

    // Scale, saturate and sign the finished product
    always_comb begin
        shifted  = sh24_reg ? (acc_reg >> PERIOD_FRAC) : (acc_reg >> FRAC_W);
        over     = (|shifted[MUL_P_W-1:63]) || (shifted[62] && (|shifted[61:0]));
        mag      = over ? {1'b1, 62'd0} : shifted[62:0];
        res_next = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Control: load, iterate, finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg && !fin_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_B_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg && !fin_reg) begin
            a_reg    <= req.a_mag;
            b_reg    <= req.b_mag;
            sh24_reg <= req.shift24;
            neg_reg  <= req.negate;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= b_reg >> 1;
        end
        if (fin_reg) begin
            res_reg <= res_next;
        end
    end

    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

>>> rtl/fuzzy_gain_scheduled_pid.sv
// ----------------------------------------------------------------------------
// fuzzy_gain_scheduled_pid
// Fixed-point PID controller whose gains are scheduled by 7x7 fuzzy rules.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A control step runs six multiplications
// through one bit-serial multiplier. Each one loads its operands, steps
// through the 33 multiplier bits, scales the product and hands it off.
// Four more steps (level, gain, integral update, output sum) and the output
// load complete the step. The output state waits until the output register
// is free, loads it and returns to idle. A clear operation clears the
// history and goes straight to the output load with a zero result. The
// result sits in an output register, so the next sample is accepted while
// the previous result still waits. Configuration writes are always taken.
`default_nettype none

`include "assert_macros.svh"

module fuzzy_gain_scheduled_pid import fgpid_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Sample input
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [63:0]          s_tdata,   // target_value[31:0], measured_value[63:32]
    input  wire logic                 s_tuser,   // operation[0]
    // Result output
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [31:0]          m_tdata,   // drive_value[31:0]
    output      logic                 m_tuser,   // drive_clipped[0]
    // Configuration writes
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    fgpid_state_t state_reg, state_next;

    // Configuration registers
    logic signed [31:0] kp_base_reg, ki_base_reg, kd_base_reg;
    logic [31:0]        sample_per_reg, inv_per_reg;

    // Controller history
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [32:0]        last_err_reg;
    logic signed [31:0]        last_meas_reg;

    // Per-sample working registers
    logic signed [31:0] meas_reg;
    logic signed [32:0] err_reg, dm_reg;
    logic signed [33:0] de_reg;
    logic signed [63:0] rate_reg, p_reg;
    logic [2:0]         le_reg, lr_reg;
    logic signed [32:0] kp_reg, ki_reg, kd_reg;
    logic signed [31:0] y_reg;
    logic               clip_reg;
    logic               issued_reg;
    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic               m_user_reg;

    logic               accept, out_free, is_mul;
    logic signed [31:0] tgt_in, meas_in;
    logic               op_in;
    mul_req_t           mul_req;
    mul_stat_t          mul_stat;
    logic signed [63:0] mul_res;
    logic [63:0]        res_mag;
    logic signed [64:0] integ_sum;
    logic signed [65:0] y_sum;

    assign tgt_in    = $signed(s_tdata[31:0]);
    assign meas_in   = $signed(s_tdata[63:32]);
    assign op_in     = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign res_mag   = mul_res[63] ? 64'(-mul_res) : 64'(mul_res);

    assign is_mul = (state_reg == ST_RATE) || (state_reg == ST_PROP)
                 || (state_reg == ST_ITERM) || (state_reg == ST_INC)
                 || (state_reg == ST_DTERM) || (state_reg == ST_DRATE);

    fgpid_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .result  (mul_res)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) begin
                          state_next = (op_in == OP_CLEAR) ? ST_OUT : ST_RATE;
                      end
            ST_RATE:  if (mul_stat.done) state_next = ST_LEVEL;
            ST_LEVEL: state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_PROP;
            ST_PROP:  if (mul_stat.done) state_next = ST_ITERM;
            ST_ITERM: if (mul_stat.done) state_next = ST_INC;
            ST_INC:   if (mul_stat.done) state_next = ST_INTEG;
            ST_INTEG: state_next = ST_DTERM;
            ST_DTERM: if (mul_stat.done) state_next = ST_DRATE;
            ST_DRATE: if (mul_stat.done) state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Multiplier operands per state
    always_comb begin
        mul_req.start   = is_mul && !issued_reg;
        mul_req.a_mag   = '0;
        mul_req.b_mag   = '0;
        mul_req.shift24 = 1'b0;
        mul_req.negate  = 1'b0;
        unique case (state_reg)
            ST_RATE: begin
                mul_req.a_mag  = MUL_A_W'(de_reg[33] ? 34'(-de_reg) : 34'(de_reg));
                mul_req.b_mag  = {1'b0, inv_per_reg};
                mul_req.negate = de_reg[33];
            end
            ST_PROP: begin
                mul_req.a_mag  = MUL_A_W'(kp_reg[32] ? 33'(-kp_reg) : 33'(kp_reg));
                mul_req.b_mag  = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
                mul_req.negate = kp_reg[32] ^ err_reg[32];
            end
            ST_ITERM: begin
                mul_req.a_mag  = MUL_A_W'(ki_reg[32] ? 33'(-ki_reg) : 33'(ki_reg));
                mul_req.b_mag  = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
                mul_req.negate = ki_reg[32] ^ err_reg[32];
            end
            ST_INC: begin
                mul_req.a_mag   = res_mag[MUL_A_W-1:0];
                mul_req.b_mag   = {1'b0, sample_per_reg};
                mul_req.shift24 = 1'b1;
                mul_req.negate  = mul_res[63];
            end
            ST_DTERM: begin
                mul_req.a_mag  = MUL_A_W'(kd_reg[32] ? 33'(-kd_reg) : 33'(kd_reg));
                mul_req.b_mag  = dm_reg[32] ? 33'(-dm_reg) : 33'(dm_reg);
                mul_req.negate = kd_reg[32] ^ dm_reg[32];
            end
            ST_DRATE: begin
                mul_req.a_mag  = res_mag[MUL_A_W-1:0];
                mul_req.b_mag  = {1'b0, inv_per_reg};
                mul_req.negate = mul_res[63];
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // Integral update and output sum
    always_comb begin
        integ_sum = 65'(integ_reg) + 65'(mul_res);
        y_sum     = 66'(p_reg) + 66'(integ_reg) - 66'(mul_res);
    end

    // State and issue flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_stat.done) begin
                issued_reg <= 1'b0;
            end else if (mul_req.start) begin
                issued_reg <= 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_base_reg    <= 32'sd65536;
            ki_base_reg    <= '0;
            kd_base_reg    <= '0;
            sample_per_reg <= 32'd167772;
            inv_per_reg    <= 32'd6553600;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PROP_GAIN:  kp_base_reg    <= $signed(cfg_data);
                REG_INTEG_GAIN: ki_base_reg    <= $signed(cfg_data);
                REG_DERIV_GAIN: kd_base_reg    <= $signed(cfg_data);
                REG_SAMPLE_PER: sample_per_reg <= cfg_data;
                REG_INV_PER:    inv_per_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // History: clear on reset or clear; integral set in ST_INTEG, last values in ST_SUM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
        end else if (accept && (op_in == OP_CLEAR)) begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
        end else if (state_reg == ST_INTEG) begin
            priority if (integ_sum > 65'sd140737488355327) begin
                integ_reg <= {1'b0, {(INTEG_W-1){1'b1}}};
            end else if (integ_sum < -65'sd140737488355328) begin
                integ_reg <= {1'b1, {(INTEG_W-1){1'b0}}};
            end else begin
                integ_reg <= integ_sum[INTEG_W-1:0];
            end
        end else if (state_reg == ST_SUM) begin
            last_err_reg  <= err_reg;
            last_meas_reg <= meas_reg;
        end
    end

    // Working registers of one sample
    always_ff @(posedge aclk) begin
        if (accept) begin
            meas_reg <= meas_in;
            err_reg  <= 33'(tgt_in) - 33'(meas_in);
            de_reg   <= 34'(33'(tgt_in) - 33'(meas_in)) - 34'(last_err_reg);
            dm_reg   <= 33'(meas_in) - 33'(last_meas_reg);
            y_reg    <= '0;
            clip_reg <= 1'b0;
        end
        if (state_reg == ST_RATE && mul_stat.done) begin
            rate_reg <= mul_res;
        end
        if (state_reg == ST_LEVEL) begin
            le_reg <= level_of(64'(err_reg));
            lr_reg <= level_of(rate_reg);
        end
        if (state_reg == ST_GAIN) begin
            kp_reg <= 33'(kp_base_reg) + rule_offset(PROP_TBL[le_reg][lr_reg],
                                                     KP_OFS1, KP_OFS2, KP_OFS3);
            ki_reg <= 33'(ki_base_reg) + rule_offset(INTEG_TBL[le_reg][lr_reg],
                                                     KI_OFS1, KI_OFS2, KI_OFS3);
            kd_reg <= 33'(kd_base_reg) + rule_offset(DERIV_TBL[le_reg][lr_reg],
                                                     KD_OFS1, KD_OFS2, KD_OFS3);
        end
        if (state_reg == ST_PROP && mul_stat.done) begin
            p_reg <= mul_res;
        end
        if (state_reg == ST_SUM) begin
            priority if (y_sum > 66'sd2147483647) begin
                y_reg    <= 32'sh7FFFFFFF;
                clip_reg <= 1'b1;
            end else if (y_sum < -66'sd2147483648) begin
                y_reg    <= 32'sh80000000;
                clip_reg <= 1'b1;
            end else begin
                y_reg    <= y_sum[31:0];
                clip_reg <= 1'b0;
            end
        end
    end

    // Output register: load when free, drop on transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= y_reg;
            m_user_reg <= clip_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `FG_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, !s_tready)
    `FG_ASSERT_IMP(a_clip_at_limit, m_tvalid && m_tuser, m_tdata == 32'h7FFFFFFF || m_tdata == 32'h80000000)
    `FG_ASSERT_IMP(a_start_when_free, mul_req.start, !mul_stat.busy)
    `FG_ASSERT_IMP(a_done_in_mul_state, mul_stat.done, is_mul && issued_reg)

endmodule

`default_nettype wire
